@@ sv/plin_pkg.sv @@
// Shared constants, types and command/status structures of the interpolator.
package plin_pkg;

   localparam int NPOINTS    = 64;
   localparam int ADDR_W     = $clog2(NPOINTS);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int SEG_W      = 6;
   localparam int IDX_W      = 6;
   localparam int PIU_W      = 7;
   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DEN_W      = DATA_W + 1;
   localparam int NUM_W      = DEN_W + FRAC_BITS;
   localparam int REM_W      = DEN_W + 1;
   localparam int DIV_STEPS  = NUM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int CSR_ADDR_W = 3;

   localparam logic MODE_QUERY = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   localparam logic REG_POINTS = 1'b0;
   localparam logic REG_EXTRAP = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAST,
      ST_CHECK,
      ST_CLAMP,
      ST_ADDR,
      ST_TEST,
      ST_LOAD0,
      ST_LOAD1,
      ST_LOAD2,
      ST_DIV,
      ST_FRAC,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [PIU_W-1:0] points_in_use;
      logic             extrapolate;
   } cfg_type;

   typedef struct packed {
      logic              mem_wr;
      logic [ADDR_W-1:0] rd_addr;
      logic              cap_q;
      logic              cap_first;
      logic              cap_lo;
      logic              cap_hi;
      logic              div_step;
      logic              cap_frac;
      logic              mul;
      logic              load_interp;
      logic              load_clamp;
      logic [ADDR_W-1:0] seg;
   } cmd_type;

   typedef struct packed {
      logic q_le_first;
      logic q_ge_rd;
      logic q_lt_rd;
      logic out_busy;
   } stat_type;

endpackage

@@ sv/plin_if.sv @@
// Request and response channel interfaces of the interpolator.
interface plin_req_if import plin_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [IDX_W-1:0]         point_index;
   logic signed [DATA_W-1:0] point_x;
   logic signed [DATA_W-1:0] point_y;
   logic signed [DATA_W-1:0] query_x;

   modport source (output valid, mode, point_index, point_x, point_y, query_x,
                   input ready);
   modport sink (input valid, mode, point_index, point_x, point_y, query_x,
                 output ready);
endinterface

interface plin_rsp_if import plin_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_y;
   logic [SEG_W-1:0]         segment;
   logic signed [DATA_W-1:0] fraction;

   modport source (output valid, result_y, segment, fraction, input ready);
   modport sink (input valid, result_y, segment, fraction, output ready);
endinterface

@@ sv/piecewise_linear_interpolator.sv @@
// Top level of the piecewise linear interpolator: CSRs, controller and datapath.
//
//   channel   direction  handshake            word
//   req_chan  in         valid/ready          mode, point_index, point_x, point_y, query_x
//   rsp_chan  out        valid/ready          result_y, segment, fraction
//   csr       in         psel/penable/pready  points_in_use, extrapolate
//
// A write word is stored when accepted; the block stays ready. A clamped query runs accept,
// ST_LAST, ST_CHECK and ST_CLAMP. An interpolated query for segment s runs accept, ST_LAST
// and ST_CHECK in clamp mode, s+1 ST_ADDR/ST_TEST search pairs (one breakpoint read each),
// ST_LOAD0 to ST_LOAD2, ST_DIV steps (one quotient bit each), ST_FRAC, ST_MUL and ST_OUT.
// Reset idles the controller, sets points_in_use to 2 and extrapolate to 0, clears output
// valid, not the tables. A finished query waits out an output stall; the input stays blocked.
module piecewise_linear_interpolator import plin_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   plin_req_if.sink              req_chan,
   plin_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [PIU_W-1:0] points_ff;
   logic             extrap_ff;
   cfg_type          cfg;
   cmd_type          cmd;
   stat_type         stat;
   logic             req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= PIU_W'(2);
         extrap_ff <= 1'b0;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_POINTS: points_ff <= pwdata[PIU_W-1:0];
            REG_EXTRAP: extrap_ff <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_POINTS: prdata = 32'(points_ff);
         REG_EXTRAP: prdata = 32'(extrap_ff);
         default:    prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   assign cfg.points_in_use = points_ff;
   assign cfg.extrapolate   = extrap_ff;

   plin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   plin_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .point_index (req_chan.point_index),
      .point_x     (req_chan.point_x),
      .point_y     (req_chan.point_y),
      .query_x     (req_chan.query_x),
      .stat        (stat),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .result_y    (rsp_chan.result_y),
      .segment     (rsp_chan.segment),
      .fraction    (rsp_chan.fraction)
   );

`ifndef NO_ASSERTIONS
   // A query word keeps the block busy for at least the next cycle.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.mode == MODE_QUERY |=> !req_chan.ready)
      else $error("query accepted but block stayed ready");

   // A write word leaves the block ready in the cycle after it.
   a_write_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.mode == MODE_WRITE |=> req_chan.ready)
      else $error("write word did not complete in one cycle");

   // A new result only comes out of a query in progress.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(!req_chan.ready))
      else $error("result appeared while idle");
`endif

endmodule

@@ sv/plin_ctrl.sv @@
// Controller state machine: sequences table writes, range check and clamp, search, divide and multiply.
module plin_ctrl import plin_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   input  logic     req_mode,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]      n_use;
   logic [ADDR_W-1:0]     last_idx;

   always_comb begin
      if (cfg.points_in_use < PIU_W'(2)) begin
         n_use = CNT_W'(2);
      end else if (int'(cfg.points_in_use) > NPOINTS) begin
         n_use = CNT_W'(NPOINTS);
      end else begin
         n_use = CNT_W'(cfg.points_in_use);
      end
   end

   assign last_idx = ADDR_W'(n_use - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.seg   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_WRITE) begin
                  cmd.mem_wr = 1'b1;
               end else begin
                  cmd.cap_q = 1'b1;
                  idx_in    = '0;
                  state_in  = cfg.extrapolate ? ST_ADDR : ST_LAST;
               end
            end
         end
         ST_LAST: begin
            cmd.rd_addr   = last_idx;
            cmd.cap_first = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.q_le_first) begin
               idx_in   = '0;
               state_in = ST_CLAMP;
            end else if (stat.q_ge_rd) begin
               cmd.rd_addr = last_idx;
               idx_in      = last_idx;
               state_in    = ST_CLAMP;
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_CLAMP: begin
            // Keep reading the end point so the ordinate survives an output stall.
            cmd.rd_addr = idx_ff;
            if (!stat.out_busy) begin
               cmd.load_clamp = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_ADDR: begin
            cmd.rd_addr = idx_ff + ADDR_W'(1);
            state_in    = ST_TEST;
         end
         ST_TEST: begin
            if (stat.q_lt_rd || (idx_ff == last_idx - ADDR_W'(1))) begin
               state_in = ST_LOAD0;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_ADDR;
            end
         end
         ST_LOAD0: begin
            cmd.rd_addr = idx_ff;
            state_in    = ST_LOAD1;
         end
         ST_LOAD1: begin
            cmd.rd_addr = idx_ff + ADDR_W'(1);
            cmd.cap_lo  = 1'b1;
            state_in    = ST_LOAD2;
         end
         ST_LOAD2: begin
            cmd.cap_hi = 1'b1;
            cnt_in     = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FRAC;
            end else begin
               cnt_in = cnt_ff + DIV_CNT_W'(1);
            end
         end
         ST_FRAC: begin
            cmd.cap_frac = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.load_interp = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/plin_dp.sv @@
// Datapath: breakpoint memories, compares, bit-serial divider, multiplier, output word.
module plin_dp import plin_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [IDX_W-1:0]         point_index,
   input  logic signed [DATA_W-1:0] point_x,
   input  logic signed [DATA_W-1:0] point_y,
   input  logic signed [DATA_W-1:0] query_x,
   output stat_type                 stat,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] result_y,
   output logic [SEG_W-1:0]         segment,
   output logic signed [DATA_W-1:0] fraction
);

   localparam logic [NUM_W-1:0] MAG_MAX_POS = NUM_W'(32'h7fff_ffff);
   localparam logic [NUM_W-1:0] MAG_MAX_NEG = NUM_W'(33'h0_8000_0000);
   localparam int SUM_W = 2 * DATA_W - FRAC_BITS + 2;

   logic [DATA_W-1:0] x_mem [NPOINTS];
   logic [DATA_W-1:0] y_mem [NPOINTS];
   logic [DATA_W-1:0] x_rd_ff, y_rd_ff;

   logic signed [DATA_W-1:0] q_ff, first_ff, x0_ff, y0_ff, frac_ff;
   logic [NUM_W-1:0]         anum_ff;
   logic [DEN_W-1:0]         aden_ff;
   logic [REM_W-1:0]         rem_ff;
   logic                     qneg_ff, den_zero_ff, dy_neg_ff, lerp_neg_ff;
   logic [DATA_W-1:0]        ady_ff;
   logic [2*DATA_W-1:0]      prod_ff;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] result_ff, fraction_ff;
   logic [SEG_W-1:0]         segment_ff;

   logic                     wr_ok;
   logic signed [DEN_W-1:0]  den, diff, dy;
   logic signed [NUM_W-1:0]  num;
   logic [REM_W-1:0]         trial;
   logic                     trial_ge;
   logic signed [DATA_W-1:0] frac_val;
   logic [DATA_W-1:0]        afr;
   logic signed [SUM_W-1:0]  ysum;
   logic signed [DATA_W-1:0] y_sat;

   assign wr_ok = int'(point_index) < NPOINTS;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && wr_ok) begin
         x_mem[ADDR_W'(point_index)] <= point_x;
         y_mem[ADDR_W'(point_index)] <= point_y;
      end
      x_rd_ff <= x_mem[cmd.rd_addr];
      y_rd_ff <= y_mem[cmd.rd_addr];
   end

   always_comb begin
      den  = $signed({x_rd_ff[DATA_W-1], x_rd_ff}) - DEN_W'(x0_ff);
      diff = DEN_W'(q_ff) - DEN_W'(x0_ff);
      num  = {diff, {FRAC_BITS{1'b0}}};
      dy   = $signed({y_rd_ff[DATA_W-1], y_rd_ff}) - DEN_W'(y0_ff);
   end

   // One quotient bit per cycle, restoring, on magnitudes.
   assign trial    = {rem_ff[REM_W-2:0], anum_ff[NUM_W-1]};
   assign trial_ge = trial >= {1'b0, aden_ff};

   always_comb begin
      if (den_zero_ff) begin
         frac_val = '0;
      end else if (qneg_ff) begin
         frac_val = (anum_ff > MAG_MAX_NEG) ? $signed(32'h8000_0000)
                                            : $signed(DATA_W'(0) - anum_ff[DATA_W-1:0]);
      end else begin
         frac_val = (anum_ff > MAG_MAX_POS) ? $signed(32'h7fff_ffff)
                                            : $signed(anum_ff[DATA_W-1:0]);
      end
   end

   assign afr = frac_ff[DATA_W-1] ? DATA_W'(0) - DATA_W'(frac_ff) : DATA_W'(frac_ff);

   always_comb begin
      if (lerp_neg_ff) begin
         ysum = SUM_W'(y0_ff) - $signed({2'b00, prod_ff[2*DATA_W-1:FRAC_BITS]});
      end else begin
         ysum = SUM_W'(y0_ff) + $signed({2'b00, prod_ff[2*DATA_W-1:FRAC_BITS]});
      end
      if (ysum > SUM_W'(32'sh7fff_ffff)) begin
         y_sat = 32'sh7fff_ffff;
      end else if (ysum < -SUM_W'(33'sh0_8000_0000)) begin
         y_sat = $signed(32'h8000_0000);
      end else begin
         y_sat = ysum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_q) begin
         q_ff <= query_x;
      end
      if (cmd.cap_first) begin
         first_ff <= $signed(x_rd_ff);
      end
      if (cmd.cap_lo) begin
         x0_ff <= $signed(x_rd_ff);
         y0_ff <= $signed(y_rd_ff);
      end
      if (cmd.cap_hi) begin
         qneg_ff     <= num[NUM_W-1] ^ den[DEN_W-1];
         den_zero_ff <= den == '0;
         anum_ff     <= num[NUM_W-1] ? NUM_W'(0) - NUM_W'(num) : NUM_W'(num);
         aden_ff     <= den[DEN_W-1] ? DEN_W'(0) - DEN_W'(den) : DEN_W'(den);
         rem_ff      <= '0;
         dy_neg_ff   <= dy[DEN_W-1];
         ady_ff      <= dy[DEN_W-1] ? DATA_W'(DEN_W'(0) - DEN_W'(dy)) : DATA_W'(dy);
      end
      if (cmd.div_step) begin
         rem_ff  <= trial_ge ? trial - {1'b0, aden_ff} : trial;
         anum_ff <= {anum_ff[NUM_W-2:0], trial_ge};
      end
      if (cmd.cap_frac) begin
         frac_ff <= frac_val;
      end
      if (cmd.mul) begin
         prod_ff     <= ady_ff * afr;
         lerp_neg_ff <= dy_neg_ff ^ frac_ff[DATA_W-1];
      end
      if (cmd.load_interp) begin
         result_ff   <= y_sat;
         fraction_ff <= frac_ff;
         segment_ff  <= SEG_W'(cmd.seg);
      end else if (cmd.load_clamp) begin
         result_ff   <= $signed(y_rd_ff);
         fraction_ff <= '0;
         segment_ff  <= SEG_W'(cmd.seg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_interp || cmd.load_clamp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.q_le_first = q_ff <= first_ff;
      stat.q_ge_rd    = q_ff >= $signed(x_rd_ff);
      stat.q_lt_rd    = q_ff < $signed(x_rd_ff);
      stat.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign result_y  = result_ff;
   assign segment   = segment_ff;
   assign fraction  = fraction_ff;

endmodule
